// File: src/iaid_pkg.sv
// Shared constants, opcodes and control types of the indexed array with insert and delete.
package iaid_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_BITS  = 32;
    localparam int OP_BITS    = 3;
    localparam int POS_BITS   = 7;
    localparam int CNT_BITS   = 7;
    localparam int STAT_BITS  = 2;
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam int IN_BITS   = OP_BITS + POS_BITS + WORD_BITS;
    localparam int OUT_BITS  = STAT_BITS + WORD_BITS + CNT_BITS;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_GET    = 3'd3,
        OP_UPDATE = 3'd4
    } opcode_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic                 shift_up;
        logic                 shift_down;
        logic                 write;
        logic [POS_BITS-1:0]  pos;
        logic [POS_BITS-1:0]  wr_idx;
        logic [WORD_BITS-1:0] value;
    } cell_ctrl_t;

endpackage

// File: src/iaid_cell.sv
// One storage cell of the element chain: holds a word and takes it from a neighbor on a shift.
module iaid_cell
    import iaid_pkg::*;
(
    input  logic                 clk,
    input  logic [POS_BITS-1:0]  idx,
    input  cell_ctrl_t           ctrl,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    output logic [WORD_BITS-1:0] word
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.shift_up && (idx > ctrl.pos))
        begin
            word_next = left_word;
        end
        if (ctrl.shift_down && (idx >= ctrl.pos))
        begin
            word_next = right_word;
        end
        if (ctrl.write && (idx == ctrl.wr_idx))
        begin
            word_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: src/iaid_rd_tree.sv
// Registered two-level select tree that reads the cell chain at a given position.
module iaid_rd_tree
    import iaid_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [POS_BITS-1:0]  pos,
    input  logic [WORD_BITS-1:0] words [CAPACITY],
    output logic [WORD_BITS-1:0] rd_word
);

    logic [WORD_BITS-1:0] group_reg  [NUM_GROUPS];
    logic [WORD_BITS-1:0] group_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if ((g * GROUP_SIZE + j < CAPACITY) &&
                    (pos == POS_BITS'(g * GROUP_SIZE + j)))
                begin
                    group_next[g] = group_next[g] | words[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb
    begin
        rd_word = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            rd_word = rd_word | group_reg[g];
        end
    end

endmodule

// File: src/indexed_array_insert_delete_top.sv
// Top level of the indexed array with append, insert, delete, get and update.
// The block keeps an ordered array of up to 64 signed 32-bit words in a chain of
// register cells, so insert and delete move all later elements together. It takes
// one request per clock unless the result side stalls; each request gives exactly one
// result, read for get through the registered select tree that reads the cells.
// Results leave through an output register, and requests keep flowing while the result
// side stalls until both the output register and the read stage are occupied.
module indexed_array_insert_delete_top
    import iaid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: opcode[2:0], position[9:3], item_value[41:10], zero fill.
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: status[1:0], read_value[33:2], element_count[40:34], zero fill.
    output logic [OUT_BYTES*8-1:0] m_tdata
);

    logic [OP_BITS-1:0]   in_op;
    logic [POS_BITS-1:0]  in_pos;
    logic [WORD_BITS-1:0] in_value;

    assign in_op    = s_tdata[OP_BITS-1:0];
    assign in_pos   = s_tdata[OP_BITS+POS_BITS-1:OP_BITS];
    assign in_value = s_tdata[IN_BITS-1:OP_BITS+POS_BITS];

    logic                 accept;
    logic                 out_free;
    logic                 busy_reg;
    logic                 busy_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    status_t              stat_reg;
    status_t              stat_next;
    logic                 get_reg;
    logic                 get_next;
    logic [CNT_BITS-1:0]  cnt_out_reg;
    logic                 m_tvalid_reg;
    logic [OUT_BITS-1:0]  m_data_reg;
    cell_ctrl_t           ctrl;
    logic [WORD_BITS-1:0] words [CAPACITY];
    logic [WORD_BITS-1:0] rd_word;
    logic                 full;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !busy_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg >= CNT_BITS'(CAPACITY));

    always_comb
    begin
        count_next       = count_reg;
        stat_next        = ST_OK;
        get_next         = 1'b0;
        ctrl.shift_up    = 1'b0;
        ctrl.shift_down  = 1'b0;
        ctrl.write       = 1'b0;
        ctrl.pos         = in_pos;
        ctrl.wr_idx      = in_pos;
        ctrl.value       = in_value;
        unique case (in_op)
            OP_APPEND:
            begin
                ctrl.wr_idx = POS_BITS'(count_reg);
                if (full)
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    ctrl.write = accept;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            OP_INSERT:
            begin
                if (in_pos > POS_BITS'(count_reg))
                begin
                    stat_next = ST_OOB;
                end
                else if (full)
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    ctrl.shift_up = accept;
                    ctrl.write    = accept;
                    count_next    = count_reg + CNT_BITS'(1);
                end
            end
            OP_DELETE:
            begin
                if (in_pos >= POS_BITS'(count_reg))
                begin
                    stat_next = ST_OOB;
                end
                else
                begin
                    ctrl.shift_down = accept;
                    count_next      = count_reg - CNT_BITS'(1);
                end
            end
            OP_GET:
            begin
                if (in_pos >= POS_BITS'(count_reg))
                begin
                    stat_next = ST_OOB;
                end
                else
                begin
                    get_next = 1'b1;
                end
            end
            OP_UPDATE:
            begin
                if (in_pos >= POS_BITS'(count_reg))
                begin
                    stat_next = ST_OOB;
                end
                else
                begin
                    ctrl.write = accept;
                end
            end
            default:
            begin
                stat_next = ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_mid_l
            assign left_word = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_mid_r
            assign right_word = words[i+1];
        end

        iaid_cell u_cell (
            .clk        (clk),
            .idx        (POS_BITS'(i)),
            .ctrl       (ctrl),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i])
        );
    end

    iaid_rd_tree u_rd_tree (
        .clk     (clk),
        .load    (accept),
        .pos     (in_pos),
        .words   (words),
        .rd_word (rd_word)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && out_free)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= accept ? count_next : count_reg;
            if (busy_reg && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stat_reg    <= stat_next;
            get_reg     <= get_next;
            cnt_out_reg <= count_next;
        end
        if (busy_reg && out_free)
        begin
            m_data_reg <= {cnt_out_reg, (get_reg ? rd_word : WORD_BITS'(0)), stat_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, m_data_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("Element count exceeds capacity.");

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_free) |=> busy_reg)
        else $error("Pending result dropped while the output is stalled.");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(busy_reg))
        else $error("Result transfer offered without a pending request.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_data_reg[STAT_BITS-1:0] == ST_FULL)) |->
        (m_data_reg[OUT_BITS-1:STAT_BITS+WORD_BITS] == CNT_BITS'(CAPACITY)))
        else $error("Full status reported with room left.");

endmodule
